### src/srxic_pkg.sv
// shared types, constants and helpers for the serial receive input conditioner
`default_nettype none
package srxic_pkg;

  localparam int MaxLinesDef = 64;
  localparam int FillW       = 10;

  localparam int ModeIxon   = 0;
  localparam int ModeIxany  = 1;
  localparam int ModeInpck  = 2;
  localparam int ModeIgnbrk = 3;
  localparam int ModeBrkint = 4;
  localparam int ModeIgnpar = 5;
  localparam int ModeParmrk = 6;
  localparam int ModeIstrip = 7;

  localparam logic [7:0]       ModeRst      = 8'h00;
  localparam logic [63:0]      OpenRst      = 64'h0;
  localparam logic [6:0]       LineCountRst = 7'd16;
  localparam logic [FillW-1:0] BlockSizeRst = 10'd64;
  localparam logic [6:0]       StartRst     = 7'o021;
  localparam logic [6:0]       StopRst      = 7'o023;

  localparam logic [7:0] CharMask7 = 8'o177;
  localparam logic [7:0] CharFf    = 8'o377;

  typedef enum logic [1:0] {
    FLOW_NONE    = 2'd0,
    FLOW_RESUME  = 2'd1,
    FLOW_SUSPEND = 2'd2
  } flow_e;

  typedef enum logic [2:0] {
    REG_INPUT_MODE = 3'd0,
    REG_OPEN_LINES = 3'd1,
    REG_LINE_COUNT = 3'd2,
    REG_BLOCK_SIZE = 3'd3,
    REG_START_CHAR = 3'd4,
    REG_STOP_CHAR  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic             stopped;
    logic [FillW-1:0] fill;
  } line_state_t;

  typedef struct packed {
    logic             full;
    logic [FillW-1:0] fill;
  } fill_step_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    flow_e      flow_event;
    logic       break_interrupt;
    logic       block_full;
  } result_t;

  function automatic fill_step_t fill_step(input logic [FillW-1:0] fill,
                                           input logic [FillW-1:0] size);
    logic [FillW:0] inc;
    fill_step_t     r;
    inc = {1'b0, fill} + (FillW+1)'(1);
    if (inc >= {1'b0, size}) begin
      r.full = 1'b1;
      r.fill = '0;
    end else begin
      r.full = 1'b0;
      r.fill = inc[FillW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### src/serial_receive_input_conditioner_core.sv
// top level of the serial receive input conditioner
//
//   channel   direction  handshake                  payload
//   in        sink       in_valid_i / in_ready_o    unit, channel, rx_byte, error flags
//   out       source     out_valid_o / out_ready_i  line, out_byte, flags, last
//   apb       slave      psel / penable / pready    paddr, pwdata, prdata
//
// one item per cycle while not stalled; an item with n results takes n output transfers
// per-line state sits in one ram, read on accept, written as the item leaves lookup
// a forward register covers back-to-back items on the same line
// reset sets config defaults and clears per-line valid bits, no clearing pass is needed
// a stalled output holds one item in the result buffer and one in the lookup stage
`default_nettype none
module serial_receive_input_conditioner_core #(
  parameter int MAX_LINES = srxic_pkg::MaxLinesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  unit_i,
  input  wire logic [3:0]  channel_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        parity_error_i,
  input  wire logic        framing_error_i,
  input  wire logic        overrun_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       line_o,
  output logic [7:0]       out_byte_o,
  output logic             has_byte_o,
  output logic [1:0]       flow_event_o,
  output logic             break_interrupt_o,
  output logic             block_full_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(MAX_LINES);
  localparam int FW = srxic_pkg::FillW;

  // configuration
  logic [7:0]    mode_q;
  logic [63:0]   open_q;
  logic [6:0]    lcnt_q;
  logic [FW-1:0] bsize_q;
  logic [6:0]    start_q;
  logic [6:0]    stop_q;
  logic          cfg_wr;
  srxic_pkg::cfg_reg_e reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = srxic_pkg::cfg_reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= srxic_pkg::ModeRst;
      open_q  <= srxic_pkg::OpenRst;
      lcnt_q  <= srxic_pkg::LineCountRst;
      bsize_q <= srxic_pkg::BlockSizeRst;
      start_q <= srxic_pkg::StartRst;
      stop_q  <= srxic_pkg::StopRst;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        srxic_pkg::REG_INPUT_MODE: mode_q  <= pwdata[7:0];
        srxic_pkg::REG_OPEN_LINES: open_q  <= pwdata;
        srxic_pkg::REG_LINE_COUNT: lcnt_q  <= pwdata[6:0];
        srxic_pkg::REG_BLOCK_SIZE: bsize_q <= pwdata[FW-1:0];
        srxic_pkg::REG_START_CHAR: start_q <= pwdata[6:0];
        srxic_pkg::REG_STOP_CHAR:  stop_q  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      srxic_pkg::REG_INPUT_MODE: prdata = {56'h0, mode_q};
      srxic_pkg::REG_OPEN_LINES: prdata = open_q;
      srxic_pkg::REG_LINE_COUNT: prdata = {57'h0, lcnt_q};
      srxic_pkg::REG_BLOCK_SIZE: prdata = {54'h0, bsize_q};
      srxic_pkg::REG_START_CHAR: prdata = {57'h0, start_q};
      srxic_pkg::REG_STOP_CHAR:  prdata = {57'h0, stop_q};
      default:                   prdata = '0;
    endcase
  end

  // lookup stage
  logic          in_acc;
  logic [5:0]    in_line;
  logic          s1_valid_q;
  logic [5:0]    s1_line_q;
  logic [7:0]    s1_byte_q;
  logic          s1_pe_q;
  logic          s1_fe_q;
  logic          s1_ov_q;
  logic          s1_vld_q;
  logic          s1_adv;

  logic [MAX_LINES-1:0]   vld_q;
  logic                   fwd_v_q;
  logic [AW-1:0]          fwd_idx_q;
  srxic_pkg::line_state_t fwd_data_q;

  logic                   ram_we;
  srxic_pkg::line_state_t ram_wdata;
  srxic_pkg::line_state_t ram_rdata;

  assign in_line    = {unit_i, channel_i};
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = !s1_valid_q || s1_adv;

  srxic_ram #(
    .WIDTH ($bits(srxic_pkg::line_state_t)),
    .DEPTH (MAX_LINES)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_line_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (in_line[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_v_q    <= 1'b0;
      vld_q      <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_v_q    <= ram_we;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (ram_we) begin
        vld_q[s1_line_q[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_line_q  <= in_line;
      s1_byte_q  <= rx_byte_i;
      s1_pe_q    <= parity_error_i;
      s1_fe_q    <= framing_error_i;
      s1_ov_q    <= overrun_i;
      s1_vld_q   <= vld_q[in_line[AW-1:0]] || (ram_we && s1_line_q[AW-1:0] == in_line[AW-1:0]);
      fwd_idx_q  <= s1_line_q[AW-1:0];
      fwd_data_q <= ram_wdata;
    end
  end

  // per-item processing
  srxic_pkg::line_state_t cur;
  srxic_pkg::fill_step_t  fs0, fs1, fs2;
  srxic_pkg::flow_e       ev;
  srxic_pkg::result_t     slot [3];
  logic          drop, is_start, is_stop, swallow, err, brk, stopped_n;
  logic [1:0]    nb, nres;
  logic [7:0]    b0, b1, b2;
  logic [FW-1:0] size, fill_n;

  // result buffer
  srxic_pkg::result_t buf_q [3];
  srxic_pkg::result_t cur_res;
  logic [1:0] cnt_q, idx_q;
  logic [5:0] line_q;
  logic       buf_free, out_xfer;

  always_comb begin
    cur = (fwd_v_q && fwd_idx_q == s1_line_q[AW-1:0]) ? fwd_data_q
        : (s1_vld_q ? ram_rdata : '0);
    drop = ({1'b0, s1_line_q} >= lcnt_q) || ({1'b0, s1_line_q} >= 7'(MAX_LINES))
        || !open_q[s1_line_q];
    is_start  = s1_byte_q[6:0] == start_q;
    is_stop   = s1_byte_q[6:0] == stop_q;
    ev        = srxic_pkg::FLOW_NONE;
    stopped_n = cur.stopped;
    swallow   = 1'b0;
    if (mode_q[srxic_pkg::ModeIxon]) begin
      if (cur.stopped) begin
        if (is_start || mode_q[srxic_pkg::ModeIxany]) begin
          ev        = srxic_pkg::FLOW_RESUME;
          stopped_n = 1'b0;
        end
      end else if (is_stop) begin
        ev        = srxic_pkg::FLOW_SUSPEND;
        stopped_n = 1'b1;
      end
      swallow = is_start || is_stop;
    end
    err = (s1_pe_q && mode_q[srxic_pkg::ModeInpck]) || s1_fe_q || s1_ov_q;
    brk = 1'b0;
    nb  = 2'd0;
    b0  = '0;
    b1  = '0;
    b2  = '0;
    priority if (swallow) begin
      nb = 2'd0;
    end else if (err) begin
      priority if (s1_byte_q == 8'h0 && mode_q[srxic_pkg::ModeIgnbrk]) begin
        nb = 2'd0;
      end else if (s1_byte_q == 8'h0 && mode_q[srxic_pkg::ModeBrkint]) begin
        brk = 1'b1;
      end else if (s1_byte_q != 8'h0 && mode_q[srxic_pkg::ModeIgnpar]) begin
        nb = 2'd0;
      end else if (mode_q[srxic_pkg::ModeParmrk]) begin
        b0 = srxic_pkg::CharFf;
        b2 = s1_byte_q;
        nb = 2'd3;
      end else begin
        nb = 2'd1;
      end
    end else if (mode_q[srxic_pkg::ModeIstrip]) begin
      b0 = s1_byte_q & srxic_pkg::CharMask7;
      nb = 2'd1;
    end else begin
      b0 = s1_byte_q;
      nb = 2'd1;
      if (s1_byte_q == srxic_pkg::CharFf && mode_q[srxic_pkg::ModeParmrk]) begin
        b1 = srxic_pkg::CharFf;
        nb = 2'd2;
      end
    end

    size = (bsize_q == '0) ? FW'(1) : bsize_q;
    fs0  = srxic_pkg::fill_step(cur.fill, size);
    fs1  = srxic_pkg::fill_step(fs0.fill, size);
    fs2  = srxic_pkg::fill_step(fs1.fill, size);
    unique case (nb)
      2'd0:    fill_n = cur.fill;
      2'd1:    fill_n = fs0.fill;
      2'd2:    fill_n = fs1.fill;
      default: fill_n = fs2.fill;
    endcase

    if (drop) begin
      nres = 2'd0;
    end else if (nb != 2'd0) begin
      nres = nb;
    end else begin
      nres = (brk || ev != srxic_pkg::FLOW_NONE) ? 2'd1 : 2'd0;
    end

    if (nb != 2'd0) begin
      slot[0] = '{out_byte: b0, has_byte: 1'b1, flow_event: ev,
                  break_interrupt: 1'b0, block_full: fs0.full};
    end else begin
      slot[0] = '{out_byte: 8'h0, has_byte: 1'b0, flow_event: ev,
                  break_interrupt: brk, block_full: 1'b0};
    end
    slot[1] = '{out_byte: b1, has_byte: 1'b1, flow_event: srxic_pkg::FLOW_NONE,
                break_interrupt: 1'b0, block_full: fs1.full};
    slot[2] = '{out_byte: b2, has_byte: 1'b1, flow_event: srxic_pkg::FLOW_NONE,
                break_interrupt: 1'b0, block_full: fs2.full};

    ram_wdata = '{stopped: stopped_n, fill: fill_n};
  end

  assign out_valid_o = cnt_q != 2'd0;
  assign last_o      = idx_q == (cnt_q - 2'd1);
  assign out_xfer    = out_valid_o && out_ready_i;
  assign buf_free    = (cnt_q == 2'd0) || (out_xfer && last_o);
  assign s1_adv      = s1_valid_q && (nres == 2'd0 || buf_free);
  assign ram_we      = s1_adv && !drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (s1_adv && nres != 2'd0) begin
      cnt_q <= nres;
      idx_q <= 2'd0;
    end else if (out_xfer) begin
      if (last_o) begin
        cnt_q <= 2'd0;
        idx_q <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && nres != 2'd0) begin
      buf_q  <= slot;
      line_q <= s1_line_q;
    end
  end

  always_comb begin
    unique case (idx_q)
      2'd1:    cur_res = buf_q[1];
      2'd2:    cur_res = buf_q[2];
      default: cur_res = buf_q[0];
    endcase
  end

  assign line_o            = line_q;
  assign out_byte_o        = cur_res.out_byte;
  assign has_byte_o        = cur_res.has_byte;
  assign flow_event_o      = cur_res.flow_event;
  assign break_interrupt_o = cur_res.break_interrupt;
  assign block_full_o      = cur_res.block_full;

`ifndef ASSERT_OFF
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> idx_q < cnt_q)
    else $error("result index beyond result count");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && cnt_q != 2'd0)
    else $error("input stalled with no item held");

  a_event_first_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idx_q != 2'd0 |-> flow_event_o == srxic_pkg::FLOW_NONE)
    else $error("flow event on a later result");

  a_break_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && break_interrupt_o |-> !has_byte_o && last_o && !block_full_o)
    else $error("break result carries a byte");
`endif

endmodule
`default_nettype wire

### src/srxic_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none
module srxic_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire
